@@ hdl/sst_pkg.sv @@
// Shared constants and helpers for the stock span stream block.
// No dependencies; imported by stock_span_stream.
`default_nettype none

package sst_pkg;

  localparam int unsigned SpanWidth = 32;

  typedef logic [SpanWidth-1:0] span_t;

  localparam span_t SpanMax = {SpanWidth{1'b1}};

  // Saturating span accumulation.
  function automatic span_t span_sat_add(input span_t a, input span_t b);
    logic [SpanWidth:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[SpanWidth] ? SpanMax : sum[SpanWidth-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/sst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the span stack in stock_span_stream.
`default_nettype none

module sst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/stock_span_stream.sv @@
// Stock span stream top level: monotonic price/span stack held in one RAM.
// Depends on sst_pkg and sst_ram.
`default_nettype none

// For every price transaction the block returns one result transaction: the
// span (count of consecutive prices, this one included, back to the last
// earlier price that is strictly greater, saturating at 2^32-1) and
// maybe_short. The stack of (price, span) pairs lives in a circular buffer in
// one RAM with a registered read; the top entry is mirrored in registers so a
// new price can be compared at once. An item passes through a walk state and
// then a fill state for each stack entry it pops, because the single RAM read
// port refills the top entry after each pop; each item pushes one entry and
// pops on average at most one. Results leave through an output register; the
// block finishes an item only when that register is free, and takes a new
// price only between items. When a push finds the stack full, the oldest
// entry is overwritten and a sticky flag is set; from then on, a span whose
// walk empties the stack is reported with maybe_short high because it may
// miss discarded history. No clearing pass is needed after reset: only
// entries below the fill count are read.
module stock_span_stream
  import sst_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned PRICE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [PRICE_WIDTH-1:0] price_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [SpanWidth-1:0]        span_o,
  output logic                        maybe_short_o
);

  localparam int unsigned AddrW  = $clog2(STACK_DEPTH);
  localparam int unsigned CountW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EntryW = PRICE_WIDTH + SpanWidth;

  localparam logic [AddrW-1:0]  LastAddr = AddrW'(STACK_DEPTH - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(STACK_DEPTH);

  // Sequencer states
  localparam logic [1:0] StIdle = 2'd0;  // waiting for a price
  localparam logic [1:0] StWalk = 2'd1;  // compare against cached top
  localparam logic [1:0] StFill = 2'd2;  // compare against RAM read data

  logic [1:0]             state_q, state_d;
  logic [CountW-1:0]      count_q, count_d;     // valid stack entries
  logic [AddrW-1:0]       top_q, top_d;         // physical slot of top entry
  logic                   lost_q, lost_d;       // sticky: history dropped
  logic [PRICE_WIDTH-1:0] price_q, price_d;     // price being processed
  span_t                  acc_q, acc_d;         // running span
  logic [PRICE_WIDTH-1:0] cache_price_q, cache_price_d;
  span_t                  cache_span_q, cache_span_d;
  logic                   out_valid_q, out_valid_d;
  span_t                  span_q, span_d;
  logic                   short_q, short_d;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [EntryW-1:0]      ram_wdata, ram_rdata;

  logic [AddrW-1:0]       top_inc, top_dec;
  logic [PRICE_WIDTH-1:0] cur_price;
  span_t                  cur_span;
  logic                   busy, pop, out_free, finish;

  sst_ram #(
    .Width (EntryW),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // circular buffer pointer steps
  assign top_inc = (top_q == LastAddr) ? '0 : top_q + AddrW'(1);
  assign top_dec = (top_q == '0) ? LastAddr : top_q - AddrW'(1);

  // top entry: straight from the RAM right after a pop, else the mirror
  assign cur_price = (state_q == StFill) ? ram_rdata[EntryW-1:SpanWidth] : cache_price_q;
  assign cur_span  = (state_q == StFill) ? ram_rdata[SpanWidth-1:0] : cache_span_q;

  assign busy     = (state_q == StWalk) || (state_q == StFill);
  assign pop      = busy && (count_q != '0) && (cur_price <= price_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign finish   = busy && !pop && out_free;

  assign in_ready_o = (state_q == StIdle);

  // read the entry that becomes top after a pop; push over the slot above
  assign ram_raddr = top_dec;
  assign ram_we    = finish;
  assign ram_waddr = top_inc;
  assign ram_wdata = {price_q, acc_q};

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    top_d         = top_q;
    lost_d        = lost_q;
    price_d       = price_q;
    acc_d         = acc_q;
    cache_price_d = cache_price_q;
    cache_span_d  = cache_span_q;
    out_valid_d   = out_valid_q;
    span_d        = span_q;
    short_d       = short_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          price_d = price_i;
          acc_d   = span_t'(1);
          state_d = StWalk;
        end
      end
      StWalk, StFill: begin
        if (pop) begin
          acc_d   = span_sat_add(acc_q, cur_span);
          count_d = count_q - CountW'(1);
          top_d   = top_dec;
          state_d = StFill;
        end else if (finish) begin
          // result out, then push; a full stack overwrites its oldest slot
          out_valid_d   = 1'b1;
          span_d        = acc_q;
          short_d       = (count_q == '0) && lost_q;
          top_d         = top_inc;
          cache_price_d = price_q;
          cache_span_d  = acc_q;
          if (count_q == FullCount) begin
            lost_d = 1'b1;
          end else begin
            count_d = count_q + CountW'(1);
          end
          state_d = StIdle;
        end else begin
          // output slot busy: hold, keep the top mirror current
          cache_price_d = cur_price;
          cache_span_d  = cur_span;
          state_d       = StWalk;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      top_q       <= '0;
      lost_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      lost_q      <= lost_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    price_q       <= price_d;
    acc_q         <= acc_d;
    cache_price_q <= cache_price_d;
    cache_span_q  <= cache_span_d;
    span_q        <= span_d;
    short_q       <= short_d;
  end

  assign out_valid_o   = out_valid_q;
  assign span_o        = span_q;
  assign maybe_short_o = short_q;

endmodule

`default_nettype wire

@@ test/stock_span_stream_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for stock_span_stream: a directed table, then random price runs.
// Each result is checked against a queue-based span predictor. Depends on sst_pkg and the RTL.
module stock_span_stream_test;
  import sst_pkg::*;

  localparam int unsigned StackDepth    = 1024;
  localparam int unsigned PriceWidth    = 16;
  localparam int          ClkPeriod     = 10;
  localparam int          CycleLimit    = 400000;
  // Receiver hold-off: starts once this many prices are taken, mid stack fill.
  localparam int          HoldOffAt     = 600;
  localparam int          HoldOffCycles = 300;
  // Stimulus plan: random runs, then a strictly falling run that overflows the
  // stack, then random runs again with history lost.
  localparam int          RunsBeforeFill = 250;
  localparam int          FillLength     = 1040;
  localparam int          TotalPrices    = 1350;
  localparam int          MaxReports     = 10;

  typedef logic [PriceWidth-1:0] price_t;

  typedef struct packed {
    price_t price;
    span_t  span;
  } stack_entry_t;

  typedef struct packed {
    span_t span;
    logic  maybe_short;
  } span_result_t;

  // Per-transaction note: fixed = 1 means the expected result is typed in.
  typedef struct packed {
    logic         fixed;
    span_result_t res;
  } result_hint_t;

  typedef struct packed {
    price_t price;
    logic   fixed;
    span_t  span;
    logic   maybe_short;
  } dir_row_t;

  typedef enum int {SegUniform, SegTies, SegRise, SegFall, SegBits} seg_kind_e;
  typedef enum int {RdyAlways, RdyMostly, RdySeldom, RdyToggle} rdy_mode_e;

  // Directed rows, starting from an empty stack. Rows with fixed = 0 go to the
  // predictor; the rest carry results that are plain by inspection.
  localparam int DirRows = 20;
  localparam dir_row_t DirTable [DirRows] = '{
    '{16'd100,   1'b1, 32'd1, 1'b0},  // first after reset: empty stack, exact
    '{16'd100,   1'b1, 32'd2, 1'b0},  // equal price pops
    '{16'd80,    1'b1, 32'd1, 1'b0},  // lower price stops at once
    '{16'd90,    1'b1, 32'd2, 1'b0},  // pops one lower entry
    '{16'd90,    1'b0, 32'd0, 1'b0},  // equal again, spans add up
    '{16'hFFFF,  1'b0, 32'd0, 1'b0},  // max price empties the stack
    '{16'h0000,  1'b1, 32'd1, 1'b0},  // min price under max
    '{16'h0000,  1'b1, 32'd2, 1'b0},
    '{16'h0001,  1'b0, 32'd0, 1'b0},
    '{16'hFFFF,  1'b0, 32'd0, 1'b0},  // ties with max on the stack
    '{16'hFFFF,  1'b0, 32'd0, 1'b0},
    '{16'h5555,  1'b1, 32'd1, 1'b0},
    '{16'hAAAA,  1'b0, 32'd0, 1'b0},
    '{16'h0001,  1'b1, 32'd1, 1'b0},
    '{16'h8000,  1'b0, 32'd0, 1'b0},
    '{16'h7FFF,  1'b1, 32'd1, 1'b0},
    '{16'hFFFE,  1'b0, 32'd0, 1'b0},  // pops several, stops under max
    '{16'h0000,  1'b1, 32'd1, 1'b0},
    '{16'hFFFF,  1'b0, 32'd0, 1'b0},
    '{16'hFFFF,  1'b0, 32'd0, 1'b0}
  };

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  price_t price     = '0;
  logic   out_ready = 1'b0;
  logic   in_ready;
  logic   out_valid;
  span_t  span;
  logic   maybe_short;

  // Stimulus, built up front; the drain mark makes the sender wait for every
  // pending result before it offers that price.
  price_t       stim_price[$];
  bit           stim_drain[$];
  result_hint_t hint_q[$];
  span_result_t pending_spans[$];

  // Predictor state: back of the queue is the top of the stack.
  stack_entry_t mirror_stack[$];
  logic         mirror_lost = 1'b0;

  int n_taken = 0;
  int n_seen  = 0;
  int n_bad   = 0;
  int cycles  = 0;

  stock_span_stream #(
    .STACK_DEPTH(StackDepth),
    .PRICE_WIDTH(PriceWidth)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .price_i      (price),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .span_o       (span),
    .maybe_short_o(maybe_short)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Pop every entry at or below the new price, summing spans with saturation,
  // then push; a full stack drops its oldest entry and marks history as lost.
  function automatic span_result_t span_predict(input price_t p);
    span_result_t        r;
    stack_entry_t        e;
    logic [SpanWidth:0]  sum;
    r.span        = 1;
    r.maybe_short = 1'b0;
    while (mirror_stack.size() > 0 && mirror_stack[$].price <= p) begin
      sum    = {1'b0, r.span} + {1'b0, mirror_stack[$].span};
      r.span = sum[SpanWidth] ? '1 : sum[SpanWidth-1:0];
      void'(mirror_stack.pop_back());
    end
    if (mirror_stack.size() == 0 && mirror_lost) r.maybe_short = 1'b1;
    if (mirror_stack.size() == StackDepth) begin
      void'(mirror_stack.pop_front());
      mirror_lost = 1'b1;
    end
    e.price = p;
    e.span  = r.span;
    mirror_stack.insert(mirror_stack.size(), e);
    return r;
  endfunction

  task automatic add_item(input price_t p, input logic fixed, input span_result_t res,
                          input bit drain);
    result_hint_t h;
    h.fixed = fixed;
    h.res   = res;
    stim_price.insert(stim_price.size(), p);
    stim_drain.insert(stim_drain.size(), drain);
    hint_q.insert(hint_q.size(), h);
  endtask

  // One short run of a random shape: noise, many ties, rising or falling
  // slopes, or single-bit patterns.
  task automatic add_segment();
    seg_kind_e kind;
    int        len;
    price_t    val;
    kind = seg_kind_e'($urandom_range(0, 4));
    len  = $urandom_range(4, 24);
    val  = price_t'($urandom);
    repeat (len) begin
      case (kind)
        SegUniform: val = price_t'($urandom);
        SegTies:    val = price_t'($urandom_range(0, 5));
        SegRise:    val = val + price_t'($urandom_range(0, 300));
        SegFall:    val = val - price_t'($urandom_range(0, 300));
        default: begin
          val = price_t'(1) << $urandom_range(0, PriceWidth - 1);
          if ($urandom_range(0, 1) != 0) val = ~val;
        end
      endcase
      add_item(val, 1'b0, '0, 1'b0);
    end
  endtask

  // Input side: every accepted price goes through the predictor so its state
  // tracks the block; a typed row overrides the predicted result.
  always @(posedge clk) begin : take_price
    result_hint_t hint;
    span_result_t pred;
    if (rst_n && in_valid && in_ready) begin
      hint = hint_q.pop_front();
      pred = span_predict(price);
      pending_spans.insert(pending_spans.size(), hint.fixed ? hint.res : pred);
      n_taken++;
    end
  end

  // Output side: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_span
    span_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_spans.size() == 0) begin
        n_bad++;
        if (n_bad <= MaxReports)
          $display("unexpected result %0d: span %0d maybe_short %0b",
                   n_seen, span, maybe_short);
      end else begin
        want = pending_spans.pop_front();
        if (want.span !== span || want.maybe_short !== maybe_short) begin
          n_bad++;
          if (n_bad <= MaxReports)
            $display("result %0d: expected span %0d maybe_short %0b, %s %0d %s %0b",
                     n_seen, want.span, want.maybe_short, "got span", span,
                     "maybe_short", maybe_short);
        end
      end
      n_seen++;
    end
  end

  // Receiver: stretches of always-ready, mostly-ready, seldom-ready and
  // toggling, plus one long hold-off that backs the block up into its input.
  initial begin : drive_out_ready
    rdy_mode_e mode;
    int        left;
    bit        held;
    mode = RdyAlways;
    left = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && n_taken >= HoldOffAt) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
      end
      if (left == 0) begin
        mode = rdy_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        RdyAlways: out_ready <= 1'b1;
        RdyMostly: out_ready <= ($urandom_range(0, 3) != 0);
        RdySeldom: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ~out_ready;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("stock_span_stream test failed");
      $finish;
    end
  end

  initial begin : run_test
    int     idx;
    int     burst;
    int     gap;
    price_t val;

    // Directed table first.
    for (idx = 0; idx < DirRows; idx++)
      add_item(DirTable[idx].price, DirTable[idx].fixed,
               {DirTable[idx].span, DirTable[idx].maybe_short}, 1'b0);

    // Random runs on a shallow stack; the block is drained before they start.
    add_segment();
    stim_drain[DirRows] = 1'b1;
    while (stim_price.size() < RunsBeforeFill) add_segment();

    // Strictly falling run: the first max price clears the stack, then every
    // price pushes with no pop until the stack overflows and loses history.
    val = '1;
    add_item(val, 1'b0, '0, 1'b1);
    repeat (FillLength - 1) begin
      val = val - price_t'($urandom_range(1, 50));
      add_item(val, 1'b0, '0, 1'b0);
    end

    // With history lost, a walk that empties the stack flags maybe_short.
    add_item('0, 1'b0, '0, 1'b0);
    add_item('1, 1'b0, '0, 1'b0);
    while (stim_price.size() < TotalPrices - 1) add_segment();
    add_item('1, 1'b0, '0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender: bursts of random length with random gaps, valid held until taken.
    burst = 0;
    for (idx = 0; idx < stim_price.size(); idx++) begin
      if (stim_drain[idx]) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_spans.size() != 0) @(negedge clk);
        burst = $urandom_range(1, 40);
      end else if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst--;
      in_valid <= 1'b1;
      price    <= stim_price[idx];
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (pending_spans.size() != 0) @(posedge clk);
    // Catch any stray result after the last expected one.
    repeat (20) @(posedge clk);
    if (n_bad == 0)
      $display("stock_span_stream test passed");
    else
      $display("stock_span_stream test failed");
    $finish;
  end

endmodule
